// File: hw/rtl/rational_arith_reduce_defines.svh
// Assertion macros for the files that check their own logic.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH
// Property p must hold at every clock edge outside reset.
`define RAR_ASSERT(label, clk, rst_n, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);
// Condition a implies condition c in the next cycle.
`define RAR_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: hw/rtl/rar_pkg.sv
package rar_pkg;
  localparam int unsigned FieldW = 32;
  localparam int unsigned DefWidth = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
    OP_EQ = 3'd4, OP_LT = 3'd5, OP_GT = 3'd6, OP_NONE = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic signed [FieldW-1:0] a_num;
    logic signed [FieldW-1:0] a_den;
    logic signed [FieldW-1:0] b_num;
    logic signed [FieldW-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] res_num;
    logic signed [FieldW-1:0] res_den;
    logic cmp_true;
    logic zero_div;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_GCD_START, ST_GCD_WAIT, ST_DIV_NUM, ST_DIV_NUM_WAIT,
    ST_DIV_DEN, ST_DIV_DEN_WAIT, ST_OUT
  } state_t;
endpackage

// File: hw/rtl/rar_if.sv
interface rar_req_if;
  import rar_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rar_rsp_if;
  import rar_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rational_arith_reduce.sv
// The back end multiplies cross terms, runs Euclid's gcd on the serial divider, then divides
// both terms by the gcd; a compare and a 0/0 result skip the remaining divider work.
// Throughput: one word at a time in the back end; the serial divider, one bit a cycle,
// runs each Euclid remainder and both final quotients, so the gcd step count sets the rate.
// The front queue holds up to DEPTH words (two by default) while the back end works.
// Reset: synchronous active-low rst_n empties the queue and returns the sequencer to idle.
`include "rational_arith_reduce_defines.svh"
module rational_arith_reduce #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth,
  parameter int unsigned DEPTH = rar_pkg::QueueDepth
) (
  input logic clk,
  input logic rst_n,
  rar_req_if.sink in_ch,
  rar_rsp_if.source out_ch
);
  import rar_pkg::*;

  logic q_valid, q_ready;
  req_t q_data;
  state_t st;

  rar_front #(.DEPTH(DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  rar_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .state(st)
  );

  `RAR_ASSERT(a_pop_only_idle, clk, rst_n, !q_ready || st == ST_IDLE, "pop outside idle")
  `RAR_ASSERT(a_flags_excl, clk, rst_n, !out_ch.valid || !(out_ch.data.cmp_true && out_ch.data.zero_div), "both flags set")
  `RAR_ASSERT_NEXT(a_out_holds, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "result dropped")
endmodule

// File: hw/rtl/rar_front.sv
module rar_front #(
  parameter int unsigned DEPTH = rar_pkg::QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rar_pkg::req_t in_data,
  output logic q_valid,
  input  logic q_ready,
  output rar_pkg::req_t q_data
);
  import rar_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Small FIFO; unused codes are normalized to OP_NONE on entry.
  req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  req_t cls;
  logic push, pop;

  always_comb begin
    cls = in_data;
    if (in_data.req_type > OP_GT) cls.req_type = OP_NONE;
  end

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    if (pop) rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end
endmodule

// File: hw/rtl/rar_divider.sv
module rar_divider #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);
  import rar_pkg::*;
  localparam int unsigned CW = $clog2(WIDTH + 1);

  // Restoring divider on magnitudes, one quotient bit a cycle, truncating signs.
  logic [WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [WIDTH:0] r_r, r_nxt, trial;
  logic qs_r, qs_nxt, rs_r, rs_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] ma, mb;

  assign ma = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign mb = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {r_r[WIDTH-1:0], q_r[WIDTH-1]} - {1'b0, d_r};

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    qs_nxt = qs_r;
    rs_nxt = rs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = ma;
      r_nxt = '0;
      d_nxt = mb;
      qs_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      rs_nxt = dividend[WIDTH-1];
      cnt_nxt = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[WIDTH]) begin
        r_nxt = trial;
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WIDTH-1:0], q_r[WIDTH-1]};
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    qs_r <= qs_nxt;
    rs_r <= rs_nxt;
  end

  assign done = done_r;
  assign quot = qs_r ? (~q_r + 1'b1) : q_r;
  assign rem = rs_r ? (~r_r[WIDTH-1:0] + 1'b1) : r_r[WIDTH-1:0];
endmodule

// File: hw/rtl/rar_back.sv
module rar_back #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  rar_pkg::req_t q_data,
  output logic out_valid,
  input  logic out_ready,
  output rar_pkg::rsp_t out_data,
  output rar_pkg::state_t state
);
  import rar_pkg::*;

  state_t st_r, st_nxt;
  logic [2:0] op_r, op_nxt;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [WIDTH-1:0] x1_r, x2_r, nm_r, dn_r, nm_nxt, dn_nxt;
  logic [WIDTH-1:0] ga_r, gb_r, ga_nxt, gb_nxt, x1_nxt, x2_nxt;
  logic turn_r, turn_nxt;
  rsp_t res_r, res_nxt;
  logic dv_start, dv_done;
  logic [WIDTH-1:0] dv_a, dv_b, dv_q, dv_r;
  logic [WIDTH-1:0] g;
  logic [WIDTH-1:0] p_ab, p_ba, p_nn, p_dd, p_db;

  // Width conversion between 32-bit fields and WIDTH-bit arithmetic.
  function automatic logic [WIDTH-1:0] fin(input logic [FieldW-1:0] v);
    logic [WIDTH+FieldW-1:0] e;
    e = {{WIDTH{v[FieldW-1]}}, v};
    return e[WIDTH-1:0];
  endfunction
  function automatic logic [FieldW-1:0] fout(input logic [WIDTH-1:0] v);
    logic [WIDTH+FieldW-1:0] e;
    e = {{FieldW{v[WIDTH-1]}}, v};
    return e[FieldW-1:0];
  endfunction
  function automatic logic slt(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

  // Wrapped products need only the low WIDTH bits.
  assign p_ab = an_r * bd_r;
  assign p_ba = bn_r * ad_r;
  assign p_nn = an_r * bn_r;
  assign p_dd = ad_r * bd_r;
  assign p_db = ad_r * bn_r;
  assign g = (ga_r == '0) ? gb_r : ga_r;

  rar_divider #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    nm_nxt = nm_r;
    dn_nxt = dn_r;
    ga_nxt = ga_r;
    gb_nxt = gb_r;
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    turn_nxt = turn_r;
    res_nxt = res_r;
    dv_start = 1'b0;
    dv_a = ga_r;
    dv_b = gb_r;
    q_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_nxt = q_data.req_type;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        x1_nxt = p_ab;
        x2_nxt = p_ba;
        res_nxt = '0;
        unique case (op_t'(op_r))
          OP_ADD: begin nm_nxt = p_ab + p_ba; dn_nxt = p_dd; end
          OP_SUB: begin nm_nxt = p_ab - p_ba; dn_nxt = p_dd; end
          OP_MUL: begin nm_nxt = p_nn; dn_nxt = p_dd; end
          OP_DIV: begin nm_nxt = p_ab; dn_nxt = p_db; end
          default: begin nm_nxt = '0; dn_nxt = '0; end
        endcase
        ga_nxt = nm_nxt;
        gb_nxt = dn_nxt;
        turn_nxt = 1'b0;
        st_nxt = (op_r <= OP_DIV) ? ST_GCD_START : ST_OUT;
        unique case (op_t'(op_r))
          OP_EQ: res_nxt.cmp_true = (p_ab == p_ba);
          OP_LT: res_nxt.cmp_true = slt(p_ab, p_ba);
          OP_GT: res_nxt.cmp_true = slt(p_ba, p_ab);
          default: res_nxt.cmp_true = 1'b0;
        endcase
      end
      ST_GCD_START: begin
        // Alternate a = a rem b and b = b rem a until one side is zero.
        if (ga_r == '0 || gb_r == '0) begin
          if (g == '0) begin
            res_nxt.zero_div = 1'b1;
            st_nxt = ST_OUT;
          end else begin
            st_nxt = ST_DIV_NUM;
          end
        end else begin
          dv_start = 1'b1;
          dv_a = turn_r ? gb_r : ga_r;
          dv_b = turn_r ? ga_r : gb_r;
          st_nxt = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (dv_done) begin
          if (turn_r) gb_nxt = dv_r;
          else ga_nxt = dv_r;
          turn_nxt = !turn_r;
          st_nxt = ST_GCD_START;
        end
      end
      ST_DIV_NUM: begin
        dv_start = 1'b1;
        dv_a = nm_r;
        dv_b = g;
        st_nxt = ST_DIV_NUM_WAIT;
      end
      ST_DIV_NUM_WAIT: begin
        if (dv_done) begin
          res_nxt.res_num = fout(dv_q);
          st_nxt = ST_DIV_DEN;
        end
      end
      ST_DIV_DEN: begin
        dv_start = 1'b1;
        dv_a = dn_r;
        dv_b = g;
        st_nxt = ST_DIV_DEN_WAIT;
      end
      ST_DIV_DEN_WAIT: begin
        if (dv_done) begin
          res_nxt.res_den = fout(dv_q);
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    nm_r <= nm_nxt;
    dn_r <= dn_nxt;
    ga_r <= ga_nxt;
    gb_r <= gb_nxt;
    x1_r <= x1_nxt;
    x2_r <= x2_nxt;
    turn_r <= turn_nxt;
    res_r <= res_nxt;
    if (st_r == ST_IDLE && q_valid) begin
      an_r <= fin(q_data.a_num);
      ad_r <= fin(q_data.a_den);
      bn_r <= fin(q_data.b_num);
      bd_r <= fin(q_data.b_den);
    end
  end

  assign out_valid = (st_r == ST_OUT);
  assign out_data = res_r;
  assign state = st_r;
endmodule
